### rtl/acknq_pkg.sv
package acknq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  // command codes on the input tuser
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_NACK = 2'd2;

  // first field in the highest bits, last in the lowest, matching the output tdata layout
  typedef struct packed {
    logic [15:0] value;
    logic [15:0] elem;
    logic [15:0] seq;
    logic [15:0] opcode;
  } frame_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_ACK,
    OP_NACK
  } op_t;

  typedef struct packed {
    op_t    op;
    frame_t frame;
  } cmd_t;

endpackage

### rtl/acknq_front.sv
module acknq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [63:0]       cfg_data,
  input  logic              cmd_pop,
  output logic              cmd_valid,
  output acknq_pkg::cmd_t   cmd
);
  import acknq_pkg::*;

  logic [63:0] critical_mask;
  logic [1:0]  fill;
  cmd_t        q0;
  cmd_t        q1;
  cmd_t        incoming;
  logic [15:0] element;
  logic        crit;
  logic        keep;
  logic        push;
  logic        pop;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (fill != 2'd2);
  assign cmd_valid     = (fill != 2'd0);
  assign cmd           = q0;

  assign element = s_axis_tdata[31:16];
  // codes outside 0..63, negative ones included, are never critical
  assign crit    = (element[15:6] == 10'd0) && critical_mask[element[5:0]];

  always_comb begin
    incoming.frame.seq    = s_axis_tdata[15:0];
    incoming.frame.elem   = s_axis_tdata[31:16];
    incoming.frame.opcode = s_axis_tdata[47:32];
    incoming.frame.value  = s_axis_tdata[63:48];
    case (s_axis_tuser)
      CMD_ENQ: begin
        keep        = 1'b1;
        incoming.op = OP_ENQ;
      end
      CMD_ACK: begin
        keep        = crit;
        incoming.op = OP_ACK;
      end
      CMD_NACK: begin
        keep        = 1'b1;
        incoming.op = OP_NACK;
      end
      default: begin
        keep        = 1'b0;
        incoming.op = OP_ENQ;
      end
    endcase
  end

  assign push = s_axis_tvalid && s_axis_tready && keep;
  assign pop  = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      critical_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      critical_mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      if (push && pop) begin
        if (fill == 2'd1) begin
          q0 <= incoming;
        end else begin
          q0 <= q1;
          q1 <= incoming;
        end
      end else if (pop) begin
        q0   <= q1;
        fill <= fill - 2'd1;
      end else if (push) begin
        if (fill == 2'd0) begin
          q0 <= incoming;
        end else begin
          q1 <= incoming;
        end
        fill <= fill + 2'd1;
      end
    end
  end

endmodule

### rtl/acknq_engine.sv
module acknq_engine #(
  parameter int DEPTH = acknq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  acknq_pkg::cmd_t   cmd,
  output logic              cmd_pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  import acknq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_NACK
  } state_t;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  frame_t             mem [DEPTH];
  frame_t             rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               we;

  state_t             state;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic signed [15:0] ack_id;
  logic               out_valid;
  frame_t             out_frame;
  logic               out_last;

  logic               out_free;
  logic               seq_le;
  logic               run_last;

  assign out_free = !out_valid || m_axis_tready;
  assign seq_le   = $signed(rd_data.seq) <= ack_id;
  assign run_last = ((idx + CW'(1)) == count);
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;

  assign we      = cmd_pop && (cmd.op == OP_ENQ) && (count < CW'(DEPTH));
  assign wr_addr = ring_add(head, count);

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = head;
      S_ACK:   rd_addr = seq_le ? ring_add(head, CW'(1)) : head;
      S_NACK:  rd_addr = out_free ? ring_add(head, idx + CW'(1)) : ring_add(head, idx);
      default: rd_addr = head;
    endcase
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= cmd.frame;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      // during replay the output register is refilled below whenever it drains
      if (out_valid && m_axis_tready && (state != S_NACK)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_ENQ: begin
                if (count < CW'(DEPTH)) begin
                  count <= count + CW'(1);
                end
              end
              OP_ACK: begin
                if (count != '0) begin
                  ack_id <= cmd.frame.seq;
                  state  <= S_ACK;
                end
              end
              OP_NACK: begin
                if (count != '0) begin
                  idx   <= '0;
                  state <= S_NACK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ACK: begin
          // rd_data holds the current head entry
          if (seq_le) begin
            head  <= ring_add(head, CW'(1));
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_NACK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_frame <= rd_data;
            out_last  <= run_last;
            if (run_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_frame;
  assign m_axis_tlast  = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond ring depth");

  a_ack_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACK) |-> (count != '0))
    else $error("ack pop on empty ring");

  a_nack_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_NACK) |-> (idx < count))
    else $error("replay index past queued frames");

  a_ring_static_on_replay: assert property (@(posedge clk) disable iff (rst)
    (state == S_NACK) |=> $stable(head) && $stable(count))
    else $error("ring changed during replay");

endmodule

### rtl/ack_nack_retransmit_queue.sv
// Retransmission buffer for critical command frames. Input transactions carry the command in
// tuser (0 enqueue, 1 ack, 2 nack) and are taken into a two-entry command queue at one per
// cycle while it is not full; acks whose element code is not marked in critical_mask, and
// command code 3, are dropped there. The back end then executes one command at a time against
// a ring of DEPTH frames held in a single-port-read memory: an enqueue writes one frame, an
// ack compares the head frames in turn and pops each one it covers until one is not covered
// or the ring runs empty, and a nack replays every queued frame in order, one frame per cycle
// while the output is not stalled, as the memory's single read port allows. A replay leaves
// the ring intact and marks its final frame with tlast; output stalls pause the replay
// without losing frames. critical_mask is to be written through the cfg port only while the
// block is idle, which the block does not enforce, and resets to zero.
module ack_nack_retransmit_queue #(
  parameter int DEPTH = acknq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // seq_id, element, frame_opcode, frame_value
  input  logic [1:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_opcode, out_seq_id, out_element, out_value
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  import acknq_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  acknq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .cmd_pop       (cmd_pop),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  acknq_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### bench/ack_nack_retransmit_queue_tb.sv
`timescale 1ns / 100ps

module ack_nack_retransmit_queue_tb;
  import acknq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [1:0] CMD_RSVD = 2'd3;
  // covers two queued commands plus the one in flight
  localparam int SETTLE_CYCLES = 4 * (DEPTH + 1);
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    frame_t frame;
    logic   last;
  } replay_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // seq_id, element, frame_opcode, frame_value
  logic [1:0]  s_axis_tuser = CMD_ENQ;  // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;  // out_opcode, out_seq_id, out_element, out_value
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  // shadow of the ring and the mask
  frame_t      ring_frame [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_count = 0;
  logic [63:0] crit_mask = '0;
  replay_t     replay_q [$];

  int          errors = 0;
  int          src_max_gap = 19;
  int          sink_max_gap = 19;
  int          sink_hold = 0;
  logic [15:0] seq_ctr = '0;

  always #1 clk = ~clk;

  ack_nack_retransmit_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic frame_t mk_frame(input logic [15:0] seq, input logic [15:0] elem,
                                      input logic [15:0] opcode, input logic [15:0] value);
    frame_t f;
    f.seq = seq;
    f.elem = elem;
    f.opcode = opcode;
    f.value = value;
    return f;
  endfunction

  // updates the shadow ring and queues the frames a nack replays
  function automatic void ring_apply(input logic [1:0] cmd, input frame_t f);
    replay_t r;
    logic    crit;
    case (cmd)
      CMD_ENQ: begin
        if (ring_count < DEPTH) begin
          ring_frame[(ring_head + ring_count) % DEPTH] = f;
          ring_count++;
        end
      end
      CMD_ACK: begin
        // only codes 0..63 can be critical
        crit = !f.elem[15] && (f.elem[14:6] == '0) && crit_mask[f.elem[5:0]];
        if (crit) begin
          while (ring_count > 0 && $signed(ring_frame[ring_head].seq) <= $signed(f.seq)) begin
            ring_head = (ring_head + 1) % DEPTH;
            ring_count--;
          end
        end
      end
      CMD_NACK: begin
        for (int i = 0; i < ring_count; i++) begin
          r.frame = ring_frame[(ring_head + i) % DEPTH];
          r.last = (i + 1 == ring_count);
          replay_q.insert(replay_q.size(), r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_cmd(input logic [1:0] cmd, input frame_t f);
    int gap;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {f.value, f.opcode, f.elem, f.seq};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    ring_apply(cmd, f);
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (replay_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [63:0] m);
    wait_idle();
    cfg_data <= m;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    crit_mask = m;
  endtask

  task automatic random_traffic(input int n);
    int         pick;
    logic [1:0] cmd;
    frame_t     f;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      f.opcode = 16'($urandom);
      f.value = 16'($urandom);
      f.seq = 16'($urandom);
      f.elem = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 63)) : 16'($urandom);
      if (pick < 50) begin
        cmd = CMD_ENQ;
        f.seq = seq_ctr;
        seq_ctr = seq_ctr + 16'($urandom_range(1, 3));
      end else if (pick < 80) begin
        cmd = CMD_ACK;
        // mostly acknowledge something recent, now and then a wild id
        if ($urandom_range(0, 5) != 0)
          f.seq = seq_ctr - 16'($urandom_range(0, 8));
      end else if (pick < 95) begin
        cmd = CMD_NACK;
      end else begin
        cmd = CMD_RSVD;
      end
      send_cmd(cmd, f);
    end
  endtask

  task automatic test_empty_ring();
    send_cmd(CMD_NACK, mk_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(CMD_ACK, mk_frame(16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_cmd(CMD_RSVD, mk_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_extremes();
    send_cmd(CMD_ENQ, mk_frame(16'h8000, 16'h0000, 16'h0000, 16'h8000));
    send_cmd(CMD_ENQ, mk_frame(16'h7FFF, 16'd63, 16'hFFFF, 16'h7FFF));
    send_cmd(CMD_ENQ, mk_frame(16'h0000, 16'd64, 16'h5A5A, 16'h0000));
    send_cmd(CMD_ENQ, mk_frame(16'hFFFF, 16'hFFFF, 16'hA5A5, 16'hFFFF));
    send_cmd(CMD_ENQ, mk_frame(16'h0001, 16'h7FFF, 16'h0001, 16'h0001));
    send_cmd(CMD_ENQ, mk_frame(16'hFFFE, 16'h8000, 16'h8000, 16'hFFFE));
    send_cmd(CMD_NACK, mk_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // mask still clear, so this ack does nothing
    send_cmd(CMD_ACK, mk_frame(16'h7FFF, 16'd0, 16'h0000, 16'h0000));
    send_cmd(CMD_NACK, mk_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    write_mask(64'h8000_0000_0000_0001);
    // out-of-range and negative element codes are never critical
    send_cmd(CMD_ACK, mk_frame(16'h7FFF, 16'd64, 16'h0000, 16'h0000));
    send_cmd(CMD_ACK, mk_frame(16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000));
    send_cmd(CMD_ACK, mk_frame(16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
    // most negative id only pops a head that equals it
    send_cmd(CMD_ACK, mk_frame(16'h8000, 16'd63, 16'h0000, 16'h0000));
    send_cmd(CMD_NACK, mk_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(CMD_ACK, mk_frame(16'h0000, 16'd0, 16'h0000, 16'h0000));
    send_cmd(CMD_ACK, mk_frame(16'h7FFF, 16'd0, 16'h0000, 16'h0000));
    send_cmd(CMD_NACK, mk_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_random_phases();
    write_mask(64'hFFFF_FFFF_FFFF_FFFF);
    seq_ctr = 16'h0000;
    random_traffic(40);
    // no idling on either side, ids run across the signed wrap
    write_mask({$urandom, $urandom});
    src_max_gap = 0;
    sink_max_gap = 0;
    seq_ctr = 16'h7FE0;
    random_traffic(40);
    write_mask(64'h0);
    sink_max_gap = 19;
    random_traffic(40);
    write_mask({$urandom, $urandom});
    src_max_gap = 19;
    seq_ctr = 16'($urandom);
    random_traffic(40);
  endtask

  // fill the ring past full, then stall the output so replays back up the input
  task automatic test_pressure();
    write_mask(64'h0);
    src_max_gap = 0;
    repeat (DEPTH + 1)
      send_cmd(CMD_ENQ, mk_frame(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom)));
    sink_hold = 400;
    repeat (8) send_cmd(CMD_NACK, mk_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    wait_idle();
    src_max_gap = 19;
  endtask

  initial begin : sink
    int gap;
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, sink_max_gap);
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    replay_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (replay_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none, actual data %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = replay_q.pop_front();
        if (m_axis_tdata[15:0] !== want.frame.opcode || m_axis_tdata[31:16] !== want.frame.seq
            || m_axis_tdata[47:32] !== want.frame.elem
            || m_axis_tdata[63:48] !== want.frame.value || m_axis_tlast !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch expected %h %h %h %h %b actual %h %h %h %h %b", $time,
                     want.frame.opcode, want.frame.seq, want.frame.elem, want.frame.value,
                     want.last, m_axis_tdata[15:0], m_axis_tdata[31:16],
                     m_axis_tdata[47:32], m_axis_tdata[63:48], m_axis_tlast);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_ring();
    test_extremes();
    test_random_phases();
    test_pressure();
    wait_idle();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
